// ===== rtl/core/assert_macros.svh =====
// Assertion helpers included by lols_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/core/lols_pkg.sv =====
package lols_pkg;
    localparam int unsigned GridWDefault = 320;
    localparam int unsigned GridHDefault = 200;
    localparam int unsigned XW = 9;
    localparam int unsigned YW = 8;
    localparam int unsigned CellW = 9;
    localparam int unsigned SumOutW = 18;
    localparam int unsigned ColorW = 8;
    localparam int unsigned SumW = 32;
    localparam int unsigned DensW = 28;
    localparam int unsigned LenW = 19;
    localparam int unsigned ProdW = 48;
    localparam int unsigned RootW = ProdW / 2;
    localparam logic [0:0] ReqWrite = 1'b0;
    localparam logic [0:0] ReqShade = 1'b1;
    localparam logic [ColorW-1:0] ColorMax = 8'd254;
    localparam int unsigned BrightFull = 255;
    localparam int unsigned DensShift = 4;
    localparam logic [0:0] CfgLightX = 1'b0;
    localparam logic [0:0] CfgLightY = 1'b1;

    typedef struct packed {
        logic [0:0]             req_type;
        logic [XW-1:0]          pos_x;
        logic [YW-1:0]          pos_y;
        logic signed [CellW-1:0] cell_value;
    } t_item;
endpackage

// ===== rtl/core/line_occlusion_light_shader.sv =====
// Shades pixels by walking a Bresenham ray from each pixel to the light
// position. Write items store one signed cell of the object grid and give no
// result; shade items give one result each. A shade result is made by the ray
// steps, each passing S_WALK, S_RD and S_ACC for one registered read of the grid
// memory, then the pixel read, the density, the product, a floor square root at
// one bit pair per cycle and the colour. A finished shade also waits while the
// previous result has not been taken. Write items are stored without leaving the
// idle state. Cells never written read back as undefined values.
module line_occlusion_light_shader #(
    parameter int unsigned GRID_W = lols_pkg::GridWDefault,
    parameter int unsigned GRID_H = lols_pkg::GridHDefault
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [0:0]                          i_req_type,
    input  logic [lols_pkg::XW-1:0]             i_pos_x,
    input  logic [lols_pkg::YW-1:0]             i_pos_y,
    input  logic signed [lols_pkg::CellW-1:0]   i_cell_value,
    output logic                                empty,
    input  logic                                pop,
    output logic [lols_pkg::ColorW-1:0]         o_pixel_color,
    output logic signed [lols_pkg::SumOutW-1:0] o_ray_sum,
    input  logic                                i_cfg_we,
    input  logic [0:0]                          i_cfg_index,
    input  logic [lols_pkg::XW-1:0]             i_cfg_data
);
    import lols_pkg::*;

    // Light position registers; the user writes them only while the block is idle, the block does not check.
    logic [XW-1:0] r_light_x;
    logic [YW-1:0] r_light_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_x <= '0;
            r_light_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgLightX: r_light_x <= i_cfg_data;
                CfgLightY: r_light_y <= i_cfg_data[YW-1:0];
                default: ;
            endcase
        end
    end

    t_item in_item;
    t_item q_item;
    logic  q_valid;
    logic  b_ready;
    logic  res_valid;

    assign in_item = '{req_type: i_req_type, pos_x: i_pos_x, pos_y: i_pos_y,
                       cell_value: i_cell_value};

    // Front: input queue that decouples the pusher from the ray walker.
    lols_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (in_item),
        .o_valid (q_valid),
        .i_ready (b_ready),
        .o_item  (q_item)
    );

    // Back: grid memory, ray walk, square root and colour; a result register
    // holds one finished transfer while the walker starts the next item.
    lols_back #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .o_ready     (b_ready),
        .i_item      (q_item),
        .i_light_x   (r_light_x),
        .i_light_y   (r_light_y),
        .o_res_valid (res_valid),
        .i_res_ready (pop),
        .o_color     (o_pixel_color),
        .o_sum       (o_ray_sum)
    );

    assign empty = !res_valid;
endmodule

// ===== rtl/core/lols_front.sv =====
module lols_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  lols_pkg::t_item   i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output lols_pkg::t_item   o_item
);
    import lols_pkg::*;

    // Two-entry queue between the pusher and the back.
    logic [1:0]  r_cnt;
    logic        r_wp;
    logic        r_rp;
    t_item       r_q [2];

    logic do_push;
    logic do_pop;
    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (do_push) r_wp <= !r_wp;
            if (do_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_q[r_wp] <= i_item;
    end
endmodule

// ===== rtl/core/lols_back.sv =====
module lols_back #(
    parameter int unsigned GRID_W = lols_pkg::GridWDefault,
    parameter int unsigned GRID_H = lols_pkg::GridHDefault
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  lols_pkg::t_item                    i_item,
    input  logic [lols_pkg::XW-1:0]            i_light_x,
    input  logic [lols_pkg::YW-1:0]            i_light_y,
    output logic                               o_res_valid,
    input  logic                               i_res_ready,
    output logic [lols_pkg::ColorW-1:0]        o_color,
    output logic signed [lols_pkg::SumOutW-1:0] o_sum
);
    import lols_pkg::*;
    `include "assert_macros.svh"

    localparam int unsigned Depth = GRID_W * GRID_H;
    localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CW = XW + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_WALK, S_RD, S_ACC, S_PIX, S_PIXACC, S_DENS, S_MUL, S_ROOT, S_COL, S_OUT
    } t_state;

    logic signed [CellW-1:0] r_mem [Depth];
    logic signed [CellW-1:0] r_rd;
    logic [AW-1:0]           n_addr;
    logic                    n_rd_in;

    t_state r_state;
    logic signed [CW-1:0] r_x, r_y, r_lx, r_ly, r_dx, r_dy, r_err;
    logic signed [CW-1:0] r_px, r_py;
    logic r_sx, r_sy, r_inb;
    logic signed [SumW-1:0] r_sum;
    logic signed [CellW-1:0] r_pix;
    logic [DensW-1:0] r_dens;
    logic [ProdW-1:0] r_v, r_res, r_bit;
    logic [5:0] r_it;
    logic [ColorW-1:0] r_color;
    logic signed [SumOutW-1:0] r_osum;
    logic r_out;

    logic signed [CW:0] e2;
    logic [LenW-1:0] len;
    logic [ProdW-1:0] trial;

    assign o_ready = (r_state == S_IDLE);
    assign o_res_valid = r_out;
    assign o_color = r_color;
    assign o_sum = r_osum;
    assign e2 = {r_err, 1'b0};
    assign len = LenW'(r_dx) * LenW'(r_dx) + LenW'(r_dy) * LenW'(r_dy);
    assign trial = r_res + r_bit;

    // Address of the cell at (r_x, r_y); in-bounds flag is taken alongside.
    always_comb begin
        n_rd_in = (r_x >= 0) && (r_y >= 0) && (r_x < CW'(GRID_W)) && (r_y < CW'(GRID_H));
        n_addr  = AW'(AW'(r_y) * AW'(GRID_W) + AW'(r_x));
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready && i_item.req_type == ReqWrite
            && 32'(i_item.pos_x) < GRID_W && 32'(i_item.pos_y) < GRID_H) begin
            r_mem[AW'(i_item.pos_y * GRID_W + i_item.pos_x)] <= i_item.cell_value;
        end
        r_rd <= r_mem[n_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out   <= 1'b0;
        end else begin
            if (r_out && i_res_ready) r_out <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && i_item.req_type == ReqShade) begin
                        r_x  <= CW'(i_item.pos_x);
                        r_y  <= CW'(i_item.pos_y);
                        r_px <= CW'(i_item.pos_x);
                        r_py <= CW'(i_item.pos_y);
                        r_lx <= CW'(i_light_x);
                        r_ly <= CW'(i_light_y);
                        r_sx <= i_item.pos_x < i_light_x;
                        r_sy <= i_item.pos_y < i_light_y;
                        r_dx <= (i_light_x > i_item.pos_x) ? CW'(i_light_x - i_item.pos_x)
                                                           : CW'(i_item.pos_x - i_light_x);
                        r_dy <= (i_light_y > i_item.pos_y) ? CW'(i_light_y - i_item.pos_y)
                                                           : CW'(i_item.pos_y - i_light_y);
                        r_sum <= '0;
                        r_state <= S_WALK;
                        r_err <= '0;
                    end
                end
                S_WALK: begin
                    if (r_err == 0 && r_sum == 0 && r_x == r_px && r_y == r_py) begin
                        r_err <= r_dx - r_dy;
                    end
                    if (r_x == r_lx && r_y == r_ly) begin
                        r_x <= r_px;
                        r_y <= r_py;
                        r_state <= S_PIX;
                    end else begin
                        r_inb <= n_rd_in;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_inb) r_sum <= r_sum + SumW'(r_rd);
                    if (e2 > -$signed({r_dy[CW-1], r_dy})) begin
                        r_x <= r_sx ? r_x + CW'(1) : r_x - CW'(1);
                    end
                    r_err <= r_err
                        - ((e2 > -$signed({r_dy[CW-1], r_dy})) ? r_dy : '0)
                        + ((e2 < $signed({r_dx[CW-1], r_dx})) ? r_dx : '0);
                    if (e2 < $signed({r_dx[CW-1], r_dx})) begin
                        r_y <= r_sy ? r_y + CW'(1) : r_y - CW'(1);
                    end
                    r_state <= S_WALK;
                end
                S_PIX: begin
                    r_inb <= n_rd_in;
                    r_state <= S_PIXACC;
                end
                S_PIXACC: begin
                    r_state <= S_DENS;
                end
                S_DENS: begin
                    r_pix <= r_inb ? r_rd : '0;
                    if (r_sum == 0) r_dens <= DensW'(1);
                    else if (r_sum < 0) r_dens <= '0;
                    else r_dens <= DensW'(r_sum >>> DensShift);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_v   <= ProdW'(len) * ProdW'(r_dens);
                    r_res <= '0;
                    r_bit <= ProdW'(1) << (2 * (RootW - 1));
                    r_it  <= 6'(RootW);
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (r_v >= trial) begin
                        r_v   <= r_v - trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_it  <= r_it - 6'd1;
                    if (r_it == 6'd1) r_state <= S_COL;
                end
                S_COL: begin
                    if (!r_out) begin
                        logic signed [10:0] col;
                        col = 11'(r_pix) + ((r_res >= ProdW'(BrightFull)) ? 11'sd0
                              : 11'(BrightFull) - 11'(r_res[8:0]));
                        r_color <= (col < 0) ? '0 : (col > 11'sd254) ? ColorMax : col[7:0];
                        r_osum <= (r_sum > SumW'(131071)) ? 18'sd131071
                                : (r_sum < -SumW'(131072)) ? -18'sd131072
                                : SumOutW'(r_sum);
                        r_out <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_NEVER(a_root_bounded, i_clk, i_rst_n, r_state == S_ROOT && r_it == 6'd0,
        "root iteration count underflow")
    `ASSERT_IMPL(a_busy_no_take, i_clk, i_rst_n, r_state != S_IDLE, !o_ready,
        "back accepted item while busy")
    `ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, r_out && !i_res_ready, ##1 r_out,
        "result dropped before transfer")
endmodule
